### hdl/group_mean_stdev_defines.svh
// ----------------------------------------------------------------------------
// group_mean_stdev_defines: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef GROUP_MEAN_STDEV_DEFINES_SVH
`define GROUP_MEAN_STDEV_DEFINES_SVH

`ifndef SYNTHESIS

`define GMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("group_mean_stdev: assertion failed");

`define GMS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `GMS_ASSERT(lbl, clk, rstn, !(cond))

`else

`define GMS_ASSERT(lbl, clk, rstn, prop)

`define GMS_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### hdl/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg: shared types and constants
// Word layouts, job record, sequencer states and arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 65535;

  localparam int CNT_W  = 16;            // sample count
  localparam int SUM_W  = 32;            // running sum
  localparam int SQ_W   = 48;            // running sum of squares
  localparam int HALF_W = SQ_W / 2;      // sum of squares split for the multiplier
  localparam int MUL_W  = 32;            // multiplier operand width
  localparam int PROD_W = 2 * MUL_W;     // product, variance numerator, root
  localparam int DIV_W  = SUM_W + 2;     // dividend width of the divider
  localparam int DEN_W  = CNT_W + 1;     // divisor width of the divider
  localparam int RES_W  = 16;            // result field width

  localparam int FIFO_DEPTH = 2;

  localparam logic [PROD_W-1:0] ROOT_BIT0 = PROD_W'(1) << (PROD_W - 2);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               empty_group;
  } gms_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] mean;
    logic        [RES_W-1:0] stdev;
    logic                    overflow;
  } gms_out_t;

  typedef struct packed {
    logic        [CNT_W-1:0] count;
    logic signed [SUM_W-1:0] sum;
    logic        [SQ_W-1:0]  sumsq;
    logic                    overflow;
  } gms_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gms_fifo_stat_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } gms_div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_DIV_MEAN,
    ST_DIV_SD,
    ST_DONE
  } gms_state_e;

endpackage

`default_nettype wire

### hdl/gms_front.sv
// ----------------------------------------------------------------------------
// gms_front: sample accumulator
// Keeps count, sum and sum of squares; hands a job on at each group close.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_front import gms_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gms_in_t        in_word_i,
  input  gms_fifo_stat_t fifo_stat_i,
  output logic           push_o,
  output gms_job_t       job_o
);

  logic        [CNT_W-1:0]         count_q, count_d;
  logic signed [SUM_W-1:0]         sum_q, sum_d;
  logic        [SQ_W-1:0]          sumsq_q, sumsq_d;
  logic                            ovf_q, ovf_d;
  logic                            accept, take, room, close;
  logic signed [SUM_W-1:0]         value, value_neg;
  logic        [SAMPLE_BITS-1:0]   mag;
  logic        [2*SAMPLE_BITS-1:0] square;

  assign in_stall_o = fifo_stat_i.full;
  assign accept     = in_valid_i && !fifo_stat_i.full;
  assign take       = accept && !in_word_i.empty_group;
  assign room       = count_q != CNT_W'(MAX_SAMPLES);
  assign close      = accept && (in_word_i.last || in_word_i.empty_group);

  assign value     = SUM_W'(signed'(in_word_i.sample[SAMPLE_BITS-1:0]));
  assign value_neg = -value;
  assign mag       = value[SUM_W-1] ? value_neg[SAMPLE_BITS-1:0] : value[SAMPLE_BITS-1:0];
  assign square    = mag * mag;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    ovf_d   = ovf_q;
    if (take) begin
      if (room) begin
        count_d = count_q + CNT_W'(1);
        sum_d   = sum_q + value;
        sumsq_d = sumsq_q + SQ_W'(square);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign push_o         = close;
  assign job_o.count    = count_d;
  assign job_o.sum      = sum_d;
  assign job_o.sumsq    = sumsq_d;
  assign job_o.overflow = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      ovf_q   <= 1'b0;
    end else if (close) begin
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

### hdl/gms_fifo.sv
// ----------------------------------------------------------------------------
// gms_fifo: job queue
// Short register queue between the accumulator and the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_fifo import gms_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gms_job_t       job_i,
  input  logic           pop_i,
  output gms_job_t       job_o,
  output gms_fifo_stat_t stat_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  gms_job_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             do_push, do_pop;

  assign stat_o.full  = level_q == LVL_W'(FIFO_DEPTH);
  assign stat_o.empty = level_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    level_d = level_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      level_d = level_q + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

endmodule

`default_nettype wire

### hdl/gms_div.sv
// ----------------------------------------------------------------------------
// gms_div: restoring divider
// One quotient bit per cycle; quotient is presented on the final step.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_div import gms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gms_div_req_t     req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, num_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  // remainder stays below the divisor, so the top bit drops
  assign rem_d   = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign num_d   = {num_q[DIV_W-2:0], ge};

  assign done_o = busy_q && (step_q == STEP_W'(DIV_W - 1));
  assign quo_o  = num_d;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/gms_back.sv
// ----------------------------------------------------------------------------
// gms_back: group arithmetic sequencer
// Variance numerator, integer root, mean and stdev divisions, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_back import gms_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gms_job_t       job_i,
  input  gms_fifo_stat_t fifo_stat_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gms_out_t       out_word_o
);

  gms_state_e state_q, state_d;

  logic [CNT_W-1:0]  m_q;
  logic              neg_q;
  logic [SUM_W-1:0]  abs_q;
  logic [SQ_W-1:0]   sumsq_q;
  logic              ovf_q;
  logic [1:0]        step_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] d_q;       // variance numerator, then root remainder
  logic [PROD_W-1:0] root_q;
  logic [PROD_W-1:0] bit_q;
  logic [RES_W-1:0]  mean_q, sd_q;
  logic              out_valid_q;
  gms_out_t          out_q;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] trial;
  logic [SUM_W-1:0]  job_neg_sum;
  logic [RES_W-1:0]  quo_lo;
  logic              root_last, res_load;
  gms_div_req_t      div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  gms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign root_last   = bit_q[0];
  assign trial       = root_q + bit_q;
  assign job_neg_sum = -job_i.sum;
  assign quo_lo      = div_quo[RES_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!fifo_stat_i.empty) begin
          state_d = (job_i.count == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_q == 2'd3) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_last) begin
          state_d = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          state_d = ST_DIV_SD;
        end
      end
      ST_DIV_SD: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o         = 1'b0;
    res_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = DIV_W'({abs_q, 1'b0}) + DIV_W'(m_q);
    div_req.den   = {m_q, 1'b0};
    case (state_q)
      ST_IDLE: pop_o = !fifo_stat_i.empty;
      ST_ROOT: div_req.start = root_last;
      ST_DIV_MEAN: begin
        div_req.start = div_done;
        div_req.num   = root_q[DIV_W-1:0];
        div_req.den   = {1'b0, m_q};
      end
      ST_DONE: res_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // one shared multiplier: |sum|^2, then m times each half of the square sum
  always_comb begin
    mul_a = MUL_W'(m_q);
    mul_b = MUL_W'(sumsq_q[HALF_W-1:0]);
    case (step_q)
      2'd0: begin
        mul_a = abs_q;
        mul_b = abs_q;
      end
      2'd2: mul_b = MUL_W'(sumsq_q[SQ_W-1:HALF_W]);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        m_q     <= job_i.count;
        neg_q   <= job_i.sum[SUM_W-1];
        abs_q   <= job_i.sum[SUM_W-1] ? job_neg_sum : job_i.sum;
        sumsq_q <= job_i.sumsq;
        ovf_q   <= job_i.overflow;
        mean_q  <= '0;
        sd_q    <= '0;
      end
      ST_MUL: begin
        prod_q <= mul_a * mul_b;
        case (step_q)
          2'd1: d_q <= -prod_q;
          2'd2: d_q <= d_q + prod_q;
          2'd3: begin
            d_q    <= d_q + (prod_q << HALF_W);
            root_q <= '0;
            bit_q  <= ROOT_BIT0;
          end
          default: ;
        endcase
      end
      ST_ROOT: begin
        if (d_q >= trial) begin
          d_q    <= d_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          mean_q <= neg_q ? -quo_lo : quo_lo;
        end
      end
      ST_DIV_SD: begin
        if (div_done) begin
          sd_q <= quo_lo;
        end
      end
      default: ;
    endcase
    if (res_load) begin
      out_q.mean     <= mean_q;
      out_q.stdev    <= sd_q;
      out_q.overflow <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= (state_q == ST_MUL) ? step_q + 2'd1 : 2'd0;
      out_valid_q <= res_load || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### hdl/group_mean_stdev.sv
// ----------------------------------------------------------------------------
// group_mean_stdev: per-group mean and population standard deviation
//
//   channel   dir   word                 handshake
//   in        in    gms_in_t  sample     in_valid_i / in_stall_o
//   out       out   gms_out_t result     out_valid_o / out_stall_i
//
// Samples are accumulated at one word per cycle unless in_stall_o is high.
// A closing word queues a job for the arithmetic sequencer, which runs each
// group through the shared 32x32 multiplier, the bit-pair square root and
// the two divisions on the shared restoring divider. Empty groups skip these.
// in_stall_o is high while the two-entry job queue is full.
// Reset clears the accumulators, queue and sequencer; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "group_mean_stdev_defines.svh"

module group_mean_stdev import gms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gms_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gms_out_t out_word_o
);

  logic           push, pop;
  gms_job_t       job_in, job_out;
  gms_fifo_stat_t fifo_stat;

  gms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .job_o       (job_in)
  );

  gms_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (fifo_stat)
  );

  gms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  `GMS_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && fifo_stat.full)
  `GMS_ASSERT(a_pop_has_job, clk_i, rst_ni, pop |-> !fifo_stat.empty)
  `GMS_ASSERT(a_job_queued, clk_i, rst_ni, push |=> !fifo_stat.empty)

endmodule

`default_nettype wire
